// ===== design/bfa_pkg.sv =====
// Shared codes, field widths and control types of the best-fit block allocator.
package bfa_pkg;

  localparam int OP_W  = 2;
  localparam int SZ_W  = 16;
  localparam int ST_W  = 2;
  localparam int IDX_W = 4;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic start;
    logic step;
    logic free;
  } bfa_trk_ctrl_t;

endpackage

// ===== design/bfa_if.sv =====
// Request and response channel interfaces of the best-fit block allocator.
interface bfa_req_if;
  import bfa_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [SZ_W-1:0] size_value;
  modport source (output valid, op, size_value, input ready);
  modport sink (input valid, op, size_value, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] block_index;
  logic [SZ_W-1:0]  block_size;
  modport source (output valid, status, block_index, block_size, input ready);
  modport sink (input valid, status, block_index, block_size, output ready);
endinterface

// ===== design/best_fit_block_allocator.sv =====
// Best-fit block allocator: block size table in a synchronous RAM, scanned per request.
//
// Requests come in on req (op, size_value) and results leave on rsp (status,
// block_index, block_size); each moves when valid and ready are both high.
// Every request produces exactly one result. A load of a block size, a clear
// and the unused op code finish in the accepting cycle, so their result is
// valid in the next cycle and they can follow each other every cycle while
// the receiver keeps rsp.ready high. An allocation reads the size RAM one entry
// per cycle over the loaded blocks, then passes the states S_LAST and S_DONE
// before its result is registered (an empty table goes straight to S_DONE).
// The next request can be taken in the first cycle that result is valid; the
// scan grows with the block count, set by the single read port of the
// size RAM. The block takes one request at a time and takes the next one as
// soon as its result sits in the output register and that register is being
// drained, or is empty. A stalled receiver holds the result in place and
// keeps req.ready low, as does an allocation scan in progress.
// Reset empties the table and frees every block; no clearing pass is needed
// because only entries below the block count are ever read.
module best_fit_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  bfa_req_if.sink        req,
  bfa_rsp_if.source      rsp
);
  import bfa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         count;
  logic [MAX_BLOCKS-1:0] used;
  logic [AW-1:0]         scan_addr;
  logic [AW-1:0]         cmp_idx;
  logic                  cmp_valid;
  logic [SIZE_BITS-1:0]  req_size;
  logic [SIZE_BITS-1:0]  rd_data;
  logic [SIZE_BITS-1:0]  sizes_mem [MAX_BLOCKS];

  logic                  rsp_valid;
  logic [ST_W-1:0]       status;
  logic [IDX_W-1:0]      block_index;
  logic [SZ_W-1:0]       block_size;
  logic [ST_W-1:0]       status_next;
  logic [IDX_W-1:0]      index_next;
  logic [SZ_W-1:0]       size_next;

  logic                  out_free;
  logic                  accept;
  logic                  full;
  logic                  load_ok;
  logic                  finish;
  logic                  grant;
  logic                  load_out;
  logic                  scan_end;
  logic [SIZE_BITS+SZ_W-1:0] in_ext;
  logic [SIZE_BITS-1:0]  in_size;
  logic [AW+IDX_W-1:0]   load_idx_ext;
  logic [AW+IDX_W-1:0]   best_idx_ext;
  logic [SIZE_BITS+SZ_W-1:0] best_size_ext;

  bfa_trk_ctrl_t         trk_ctrl;
  logic                  trk_found;
  logic [AW-1:0]         best_idx;
  logic [SIZE_BITS-1:0]  best_size;

  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept = req.valid && req.ready;
  assign full = (count == CW'(MAX_BLOCKS));
  assign load_ok = accept && (req.op == OP_LOAD) && !full;
  assign finish = (state == S_DONE) && out_free;
  assign grant = finish && trk_found;
  assign load_out = (accept && (req.op != OP_ALLOC)) || finish;
  assign scan_end = ((CW'(scan_addr) + CW'(1)) == count);

  assign in_ext = {{SIZE_BITS{1'b0}}, req.size_value};
  assign in_size = in_ext[SIZE_BITS-1:0];
  assign load_idx_ext = {{IDX_W{1'b0}}, count[AW-1:0]};
  assign best_idx_ext = {{IDX_W{1'b0}}, best_idx};
  assign best_size_ext = {{SZ_W{1'b0}}, best_size};

  // Size table: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      sizes_mem[count[AW-1:0]] <= in_size;
    end
    rd_data <= sizes_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      used      <= '0;
      cmp_valid <= 1'b0;
      scan_addr <= '0;
    end else begin
      cmp_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (req.op == OP_LOAD) begin
              if (!full) begin
                count <= count + CW'(1);
                used[count[AW-1:0]] <= 1'b0;
              end
            end else if (req.op == OP_ALLOC) begin
              scan_addr <= '0;
              state <= (count == '0) ? S_DONE : S_SCAN;
            end else if (req.op == OP_CLEAR) begin
              count <= '0;
              used  <= '0;
            end else begin
              count <= count;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_LAST;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        S_LAST: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (trk_found) begin
              used[best_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_addr;
    if (accept && (req.op == OP_ALLOC)) begin
      req_size <= in_size;
    end
  end

  assign trk_ctrl.start = accept && (req.op == OP_ALLOC);
  assign trk_ctrl.step  = cmp_valid;
  assign trk_ctrl.free  = !used[cmp_idx];

  bfa_best #(
    .AW (AW),
    .SW (SIZE_BITS)
  ) u_best (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (trk_ctrl),
    .idx       (cmp_idx),
    .size      (rd_data),
    .req_size  (req_size),
    .found     (trk_found),
    .best_idx  (best_idx),
    .best_size (best_size)
  );

  always_comb begin
    status_next = ST_OK;
    index_next  = '0;
    size_next   = '0;
    if (state == S_DONE) begin
      if (trk_found) begin
        status_next = ST_GRANTED;
        index_next  = best_idx_ext[IDX_W-1:0];
        size_next   = best_size_ext[SZ_W-1:0];
      end else begin
        status_next = ST_NOFIT;
      end
    end else if (req.op == OP_LOAD) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        index_next = load_idx_ext[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= status_next;
      block_index <= index_next;
      block_size  <= size_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.block_index = block_index;
  assign rsp.block_size  = block_size;

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS))
    else $error("block count exceeds table capacity");

  // A grant marks the chosen block used on the following cycle.
  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    grant |=> used[$past(best_idx)])
    else $error("granted block not marked used");

  // The chosen block always fits the request.
  a_grant_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && trk_found |-> best_size >= req_size)
    else $error("granted block smaller than request");

  // A clear empties the table and frees every block.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_CLEAR) |=> (count == '0) && (used == '0))
    else $error("clear left table state behind");

endmodule

// ===== design/bfa_best.sv =====
// Running best-fit tracker fed one table entry per cycle during a scan.
module bfa_best #(
  parameter int AW = 4,
  parameter int SW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bfa_pkg::bfa_trk_ctrl_t ctrl,
  input  logic [AW-1:0]          idx,
  input  logic [SW-1:0]          size,
  input  logic [SW-1:0]          req_size,
  output logic                   found,
  output logic [AW-1:0]          best_idx,
  output logic [SW-1:0]          best_size
);
  import bfa_pkg::*;

  logic better;

  // Strictly smaller wins, so on equal sizes the earlier entry stays.
  assign better = ctrl.step && ctrl.free && (size >= req_size) &&
                  (!found || (size < best_size));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx  <= idx;
      best_size <= size;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the best-fit block allocator with its own allocation predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int MAX_BLOCKS   = 16;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = MAX_BLOCKS + 4;
  localparam int REPORT_LIMIT = 10;

  // The fourth op code has no name in the package; the block ignores it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] block_index;
    logic [SZ_W-1:0]  block_size;
  } alloc_result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [SZ_W-1:0] value;
    logic            literal;
    alloc_result_t   want;
  } stim_row_t;

  // Rows with literal set carry their result; the others are left to the predictor.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{OP_ALLOC,  16'd0,      1'b1, '{ST_NOFIT,   4'd0,  16'd0}},
    '{OP_UNUSED, 16'hFFFF,   1'b1, '{ST_OK,      4'd0,  16'd0}},
    '{OP_LOAD,   16'd100,    1'b1, '{ST_OK,      4'd0,  16'd0}},
    '{OP_LOAD,   16'hFFFF,   1'b1, '{ST_OK,      4'd1,  16'd0}},
    '{OP_LOAD,   16'd0,      1'b1, '{ST_OK,      4'd2,  16'd0}},
    '{OP_LOAD,   16'd100,    1'b1, '{ST_OK,      4'd3,  16'd0}},
    '{OP_LOAD,   16'h8000,   1'b1, '{ST_OK,      4'd4,  16'd0}},
    '{OP_LOAD,   16'h5555,   1'b1, '{ST_OK,      4'd5,  16'd0}},
    '{OP_LOAD,   16'hAAAA,   1'b1, '{ST_OK,      4'd6,  16'd0}},
    '{OP_LOAD,   16'd1,      1'b1, '{ST_OK,      4'd7,  16'd0}},
    '{OP_LOAD,   16'd2,      1'b1, '{ST_OK,      4'd8,  16'd0}},
    '{OP_LOAD,   16'd300,    1'b1, '{ST_OK,      4'd9,  16'd0}},
    '{OP_LOAD,   16'd100,    1'b1, '{ST_OK,      4'd10, 16'd0}},
    '{OP_LOAD,   16'd7,      1'b1, '{ST_OK,      4'd11, 16'd0}},
    '{OP_LOAD,   16'h7FFF,   1'b1, '{ST_OK,      4'd12, 16'd0}},
    '{OP_LOAD,   16'h00FF,   1'b1, '{ST_OK,      4'd13, 16'd0}},
    '{OP_LOAD,   16'hFF00,   1'b1, '{ST_OK,      4'd14, 16'd0}},
    '{OP_LOAD,   16'd50,     1'b1, '{ST_OK,      4'd15, 16'd0}},
    '{OP_LOAD,   16'd5,      1'b1, '{ST_FULL,    4'd0,  16'd0}},
    '{OP_ALLOC,  16'd0,      1'b0, '0},
    '{OP_ALLOC,  16'd99,     1'b0, '0},
    '{OP_ALLOC,  16'hFFFF,   1'b1, '{ST_GRANTED, 4'd1,  16'hFFFF}},
    '{OP_ALLOC,  16'hFFFF,   1'b1, '{ST_NOFIT,   4'd0,  16'd0}},
    '{OP_CLEAR,  16'd0,      1'b1, '{ST_OK,      4'd0,  16'd0}},
    '{OP_ALLOC,  16'd0,      1'b1, '{ST_NOFIT,   4'd0,  16'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  best_fit_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_BITS (SZ_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predictor copy of the block table.
  logic [SZ_W-1:0] table_size [MAX_BLOCKS];
  bit              table_used [MAX_BLOCKS];
  int              table_count = 0;

  alloc_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            source_idle_pct = 0;
  int            sink_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic alloc_result_t predict_allocation(logic [OP_W-1:0] op,
                                                       logic [SZ_W-1:0] value);
    alloc_result_t r;
    int            best;
    bit            found;
    r = '0;
    best = 0;
    found = 1'b0;
    case (op)
      OP_LOAD: begin
        if (table_count >= MAX_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          table_size[table_count] = value;
          table_used[table_count] = 1'b0;
          r.status = ST_OK;
          r.block_index = table_count[IDX_W-1:0];
          table_count++;
        end
      end
      OP_ALLOC: begin
        // Strict less-than keeps the earliest loaded block on equal sizes.
        for (int i = 0; i < table_count; i++) begin
          if (!table_used[i] && table_size[i] >= value &&
              (!found || table_size[i] < table_size[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          table_used[best] = 1'b1;
          r.status = ST_GRANTED;
          r.block_index = best[IDX_W-1:0];
          r.block_size = table_size[best];
        end else begin
          r.status = ST_NOFIT;
        end
      end
      OP_CLEAR: begin
        foreach (table_used[i]) table_used[i] = 1'b0;
        table_count = 0;
        r.status = ST_OK;
      end
      default: r.status = ST_OK;
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(string what, alloc_result_t want, alloc_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s) at cycle %0d: expected status %0d index %0d size %0d,",
               what, cycle_count, want.status, want.block_index, want.block_size);
      $display("  got status %0d index %0d size %0d",
               got.status, got.block_index, got.block_size);
    end
  endfunction

  // Drives one request at the falling edge and holds it until the block takes it.
  task automatic issue_request(logic [OP_W-1:0] op, logic [SZ_W-1:0] value,
                               logic literal, alloc_result_t want);
    alloc_result_t predicted;
    while ($urandom_range(0, 99) < source_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.size_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_allocation(op, value);
    pending_results.push_back(literal ? want : predicted);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.block_index, rsp_ch.block_size};
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.block_index !== want.block_index ||
            got.block_size !== want.block_size) begin
          note_mismatch("result", want, got);
        end
      end
    end
  end

  initial begin
    int              sent;
    int              r;
    int              k;
    logic [OP_W-1:0] op;
    logic [SZ_W-1:0] value;

    req_ch.valid = 1'b0;
    req_ch.op = OP_LOAD;
    req_ch.size_value = '0;
    rsp_ch.ready = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    source_idle_pct = 37;
    sink_stall_pct = 81;
    foreach (DIRECTED_ROWS[i]) begin
      issue_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                    DIRECTED_ROWS[i].literal, DIRECTED_ROWS[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          source_idle_pct = 37;
          sink_stall_pct = 81;
        end
        1: begin
          source_idle_pct = 81;
          sink_stall_pct = 37;
        end
        default: begin
          source_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        // Clears are rare enough that the table often fills between them.
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_CLEAR;
        else if (r < 5) op = OP_UNUSED;
        else if (r < 45) op = OP_LOAD;
        else op = OP_ALLOC;
        value = SZ_W'($urandom);
        r = $urandom_range(0, 9);
        if (op == OP_LOAD) begin
          // Small sizes give many ties between free blocks.
          if (r < 4) value = SZ_W'($urandom_range(0, 15));
          else if (r == 4) value = $urandom_range(0, 1) ? '1 : '0;
        end else if (op == OP_ALLOC) begin
          // Most requests sit right at, below or above a stored size.
          if (r < 6 && table_count > 0) begin
            k = $urandom_range(0, table_count - 1);
            value = SZ_W'(table_size[k] + $urandom_range(0, 2) - 1);
          end else if (r == 6) begin
            value = '0;
          end else if (r == 7) begin
            value = SZ_W'($urandom_range(0, 15));
          end
        end
        issue_request(op, value, 1'b0, '0);
        if (op != OP_UNUSED) sent++;
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
